FILE: design/rbft_pkg.sv
// ----------------------------------------------------------------------------
// rbft_pkg
// shared types and constants for the rigid body frame transform
// ----------------------------------------------------------------------------
package rbft_pkg;

    localparam int QuatW   = 16;
    localparam int PosW    = 32;
    localparam int ElemW   = 16;
    localparam int CfgW    = 48;
    localparam int CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] CFG_ROW0 = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_ROW1 = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_ROW2 = 2'd2;

    // accepted body update as it sits in the queue
    typedef struct packed {
        logic signed [QuatW-1:0] qr;
        logic signed [QuatW-1:0] qi;
        logic signed [QuatW-1:0] qj;
        logic signed [QuatW-1:0] qk;
        logic signed [PosW-1:0]  px;
        logic signed [PosW-1:0]  py;
        logic signed [PosW-1:0]  pz;
    } body_item_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    function automatic logic signed [ElemW-1:0] sat16(input logic signed [63:0] v);
        logic signed [ElemW-1:0] r;
        if (v > 64'sd32767)
            r = 16'sh7fff;
        else if (v < -64'sd32768)
            r = 16'sh8000;
        else
            r = v[ElemW-1:0];
        return r;
    endfunction

endpackage

FILE: design/rbft_fifo.sv
// ----------------------------------------------------------------------------
// rbft_fifo
// short queue between the intake and the row engine
// ----------------------------------------------------------------------------
module rbft_fifo #(
    parameter int Depth = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rbft_pkg::body_item_t wdata,
    input  logic                pop,
    output rbft_pkg::body_item_t rdata,
    output rbft_pkg::fifo_stat_t stat
);
    import rbft_pkg::*;

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

    body_item_t            mem_reg [Depth];
    logic [AW-1:0]         wr_ptr_reg;
    logic [AW-1:0]         rd_ptr_reg;
    logic [AW:0]           count_reg;

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
        logic [AW-1:0] n;
        if (p == AW'(Depth - 1))
            n = '0;
        else
            n = p + AW'(1);
        return n;
    endfunction

    assign stat.full  = (count_reg == (AW+1)'(Depth));
    assign stat.empty = (count_reg == '0);
    assign rdata      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: design/rbft_engine.sv
// ----------------------------------------------------------------------------
// rbft_engine
// row engine: rotation per row, then inertia product; without an output stall, one row per cycle
// ----------------------------------------------------------------------------
module rbft_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rbft_pkg::body_item_t         item,
    input  rbft_pkg::fifo_stat_t         stat,
    output logic                         pop,
    input  logic [rbft_pkg::CfgW-1:0]    ib_row0,
    input  logic [rbft_pkg::CfgW-1:0]    ib_row1,
    input  logic [rbft_pkg::CfgW-1:0]    ib_row2,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   out_row,
    output logic                         out_last,
    output logic signed [15:0]           out_r0,
    output logic signed [15:0]           out_r1,
    output logic signed [15:0]           out_r2,
    output logic signed [31:0]           out_tr,
    output logic signed [15:0]           out_w0,
    output logic signed [15:0]           out_w1,
    output logic signed [15:0]           out_w2
);
    import rbft_pkg::*;

    // stage a: rotation matrix of the head item, all three rows, registered
    // stage b: row counter walks rows; t row = rot row * Ib, registered
    // stage c: w row = t row * R^T, rounded, into the output register
    typedef logic signed [ElemW-1:0] e16_t;

    logic               a_valid_reg;
    logic [1:0]         a_row_reg;
    e16_t               a_rot_reg [3][3];
    logic signed [PosW-1:0] a_pos_reg [3];

    logic               b_valid_reg;
    logic [1:0]         b_row_reg;
    e16_t               b_rot_reg [3][3];
    logic signed [PosW-1:0] b_tr_reg;
    logic signed [33:0] b_t_reg [3];

    logic               c_valid_reg;
    logic               adv_c, adv_b, adv_a;
    e16_t               rot_calc [3][3];
    e16_t               ib [3][3];
    logic signed [33:0] t_calc [3];
    e16_t               w_calc [3];

    always_comb
    begin
        logic signed [31:0] ii, jj, kk, ij, ik, jk, ri, rj, rk;
        logic signed [63:0] e [3][3];
        ii = item.qi * item.qi;  jj = item.qj * item.qj;  kk = item.qk * item.qk;
        ij = item.qi * item.qj;  ik = item.qi * item.qk;  jk = item.qj * item.qk;
        ri = item.qr * item.qi;  rj = item.qr * item.qj;  rk = item.qr * item.qk;
        e[0][0] = (64'sd1 <<< 28) - 2*64'(jj) - 2*64'(kk);
        e[0][1] = 2*64'(ij) - 2*64'(rk);
        e[0][2] = 2*64'(ik) + 2*64'(rj);
        e[1][0] = 2*64'(ij) + 2*64'(rk);
        e[1][1] = (64'sd1 <<< 28) - 2*64'(ii) - 2*64'(kk);
        e[1][2] = 2*64'(jk) - 2*64'(ri);
        e[2][0] = 2*64'(ik) - 2*64'(rj);
        e[2][1] = 2*64'(jk) + 2*64'(ri);
        e[2][2] = (64'sd1 <<< 28) - 2*64'(ii) - 2*64'(jj);
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                rot_calc[r][c] = sat16((e[r][c] + 64'sd8192) >>> 14);
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            ib[0][c] = ib_row0[16*c +: 16];
            ib[1][c] = ib_row1[16*c +: 16];
            ib[2][c] = ib_row2[16*c +: 16];
        end
        for (int c = 0; c < 3; c++)
            t_calc[c] = 34'(a_rot_reg[a_row_reg][0] * ib[0][c])
                      + 34'(a_rot_reg[a_row_reg][1] * ib[1][c])
                      + 34'(a_rot_reg[a_row_reg][2] * ib[2][c]);
        for (int c = 0; c < 3; c++)
            w_calc[c] = sat16((64'(b_t_reg[0] * b_rot_reg[c][0])
                             + 64'(b_t_reg[1] * b_rot_reg[c][1])
                             + 64'(b_t_reg[2] * b_rot_reg[c][2])
                             + (64'sd1 <<< 27)) >>> 28);
    end

    assign adv_c = !c_valid_reg || !out_stall;
    assign adv_b = !b_valid_reg || adv_c;
    assign adv_a = !a_valid_reg || (adv_b && a_row_reg == 2'd2);
    assign pop   = adv_a && !stat.empty;
    assign out_valid = c_valid_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_rot_reg    <= rot_calc;
            a_pos_reg[0] <= item.px;
            a_pos_reg[1] <= item.py;
            a_pos_reg[2] <= item.pz;
        end
        if (adv_b && a_valid_reg)
        begin
            b_rot_reg <= a_rot_reg;
            b_t_reg   <= t_calc;
            b_tr_reg  <= a_pos_reg[a_row_reg];
            b_row_reg <= a_row_reg;
        end
        if (adv_c && b_valid_reg)
        begin
            out_row  <= b_row_reg;
            out_last <= (b_row_reg == 2'd2);
            out_r0   <= b_rot_reg[b_row_reg][0];
            out_r1   <= b_rot_reg[b_row_reg][1];
            out_r2   <= b_rot_reg[b_row_reg][2];
            out_tr   <= b_tr_reg;
            out_w0   <= w_calc[0];
            out_w1   <= w_calc[1];
            out_w2   <= w_calc[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_row_reg   <= 2'd0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
            begin
                a_valid_reg <= pop;
                a_row_reg   <= 2'd0;
            end
            else if (adv_b)
                a_row_reg <= a_row_reg + 2'd1;
            if (adv_b)
                b_valid_reg <= a_valid_reg;
            if (adv_c)
                c_valid_reg <= b_valid_reg;
        end
    end

endmodule

FILE: design/rigid_body_frame_transform_core.sv
// ----------------------------------------------------------------------------
// rigid_body_frame_transform_core
// quaternion to rigid transform and world inverse inertia, row by row
// ----------------------------------------------------------------------------
// Each accepted body update (unit quaternion in Q1.14, position in Q16.16)
// yields three result transactions, rows 0, 1, 2, the last one flagged. A row
// carries the rotation row, the translation component and the matching row
// of R*Ib*R^T in Q4.12, rotation and inertia saturated. The row engine produces
// one row per cycle while the result channel does not stall, and takes the next
// body update only once the last row of the previous one moves on. An accepted
// update passes the queue, stage a, stage b and the output register. A
// two-entry queue sits between intake and the row engine so each side can
// stall on its own. Inertia rows must be written through the configuration
// port only while the block is idle, by the user; the block does not enforce it.
module rigid_body_frame_transform_core #(
    parameter int QueueDepth = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    // body update channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] quat_r,
    input  logic signed [15:0] quat_i,
    input  logic signed [15:0] quat_j,
    input  logic signed [15:0] quat_k,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    // row result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         row,
    output logic               last,
    output logic signed [15:0] rot_c0,
    output logic signed [15:0] rot_c1,
    output logic signed [15:0] rot_c2,
    output logic signed [31:0] translation,
    output logic signed [15:0] inertia_c0,
    output logic signed [15:0] inertia_c1,
    output logic signed [15:0] inertia_c2,
    // configuration write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [47:0]        cfg_data
);
    import rbft_pkg::*;

    logic [CfgW-1:0] ib_row0_reg, ib_row1_reg, ib_row2_reg;
    body_item_t      in_item, head_item;
    fifo_stat_t      q_stat;
    logic            q_push, q_pop;

    // front: queue the transaction
    assign in_stall = q_stat.full;
    assign q_push   = in_valid && !q_stat.full;
    assign in_item  = '{qr: quat_r, qi: quat_i, qj: quat_j, qk: quat_k,
                        px: pos_x, py: pos_y, pz: pos_z};

    assign cfg_ready = 1'b1;

    // inertia rows; an index past the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ib_row0_reg <= '0;
            ib_row1_reg <= '0;
            ib_row2_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ROW0: ib_row0_reg <= cfg_data;
                CFG_ROW1: ib_row1_reg <= cfg_data;
                CFG_ROW2: ib_row2_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    rbft_fifo #(.Depth(QueueDepth)) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (in_item),
        .pop   (q_pop),
        .rdata (head_item),
        .stat  (q_stat)
    );

    // back: rotation, inertia product and output register
    rbft_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (head_item),
        .stat      (q_stat),
        .pop       (q_pop),
        .ib_row0   (ib_row0_reg),
        .ib_row1   (ib_row1_reg),
        .ib_row2   (ib_row2_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_row   (row),
        .out_last  (last),
        .out_r0    (rot_c0),
        .out_r1    (rot_c1),
        .out_r2    (rot_c2),
        .out_tr    (translation),
        .out_w0    (inertia_c0),
        .out_w1    (inertia_c1),
        .out_w2    (inertia_c2)
    );

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the rigid body frame transform core
// ----------------------------------------------------------------------------
// Body updates go in on a valid/stall channel and each one yields three row
// transactions. A small scoreboard predicts the rows from its own copy of the
// inertia registers and compares every output field in order. Registers are
// written only with nothing in flight. Both sides idle in random bursts only
// in the random phases, not in the directed part or the last part of the run.
// ----------------------------------------------------------------------------
module testbench;
    import rbft_pkg::*;

    typedef struct {
        logic [1:0]         row;
        logic               last;
        logic signed [15:0] rot [3];
        logic signed [31:0] trans;
        logic signed [15:0] inert [3];
    } row_result_t;

    // scoreboard: holds the inertia registers and the pending rows
    class row_scoreboard;
        logic [47:0] inertia_rows [3];
        row_result_t pending_rows [$];
        int          mismatches;

        function new();
            for (int i = 0; i < 3; i++)
            begin
                inertia_rows[i] = '0;
            end
            mismatches = 0;
        endfunction

        function void write_inertia(logic [1:0] idx, logic [47:0] val);
            if (idx <= CFG_ROW2)
            begin
                inertia_rows[idx] = val;
            end
        endfunction

        // round by half then floor shift, saturate to 16 bits
        function longint round_sat(longint v, int sh);
            longint r;
            r = (v + (longint'(1) << (sh - 1))) >>> sh;
            if (r > 32767)
                r = 32767;
            if (r < -32768)
                r = -32768;
            return r;
        endfunction

        function void note_body(body_item_t b);
            longint qr, qi, qj, qk, one, s;
            longint e [3][3];
            longint rot [3][3];
            longint ib [3][3];
            longint t [3][3];
            row_result_t res;
            logic signed [31:0] pos [3];
            logic signed [15:0] el;
            qr = b.qr;
            qi = b.qi;
            qj = b.qj;
            qk = b.qk;
            one = longint'(1) << 28;
            pos[0] = b.px;
            pos[1] = b.py;
            pos[2] = b.pz;
            e[0][0] = one - 2*qj*qj - 2*qk*qk;
            e[0][1] = 2*qi*qj - 2*qr*qk;
            e[0][2] = 2*qi*qk + 2*qr*qj;
            e[1][0] = 2*qi*qj + 2*qr*qk;
            e[1][1] = one - 2*qi*qi - 2*qk*qk;
            e[1][2] = 2*qj*qk - 2*qr*qi;
            e[2][0] = 2*qi*qk - 2*qr*qj;
            e[2][1] = 2*qj*qk + 2*qr*qi;
            e[2][2] = one - 2*qi*qi - 2*qj*qj;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    rot[r][c] = round_sat(e[r][c], 14);
                    el = inertia_rows[r][16*c +: 16];
                    ib[r][c] = el;
                end
            end
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    s = 0;
                    for (int m = 0; m < 3; m++)
                        s += rot[r][m] * ib[m][c];
                    t[r][c] = s;
                end
            end
            for (int r = 0; r < 3; r++)
            begin
                res.row = r[1:0];
                res.last = (r == 2);
                res.trans = pos[r];
                for (int c = 0; c < 3; c++)
                begin
                    s = 0;
                    for (int m = 0; m < 3; m++)
                        s += t[r][m] * rot[c][m];
                    res.rot[c] = 16'(rot[r][c]);
                    res.inert[c] = 16'(round_sat(s, 28));
                end
                pending_rows.push_back(res);
            end
        endfunction

        function void report(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            mismatches++;
        endfunction

        function void check_row(row_result_t got);
            row_result_t want;
            if (pending_rows.size() == 0)
            begin
                report("unexpected row", got.row, 0);
                return;
            end
            want = pending_rows.pop_front();
            if (got.row !== want.row) report("row", got.row, want.row);
            if (got.last !== want.last) report("last", got.last, want.last);
            if (got.trans !== want.trans) report("translation", got.trans, want.trans);
            for (int c = 0; c < 3; c++)
            begin
                if (got.rot[c] !== want.rot[c])
                    report($sformatf("rot_c%0d", c), got.rot[c], want.rot[c]);
                if (got.inert[c] !== want.inert[c])
                    report($sformatf("inertia_c%0d", c), got.inert[c], want.inert[c]);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid, in_stall;
    logic signed [15:0] quat_r, quat_i, quat_j, quat_k;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic out_valid, out_stall;
    logic [1:0] row;
    logic last;
    logic signed [15:0] rot_c0, rot_c1, rot_c2;
    logic signed [31:0] translation;
    logic signed [15:0] inertia_c0, inertia_c1, inertia_c2;
    logic cfg_valid, cfg_ready;
    logic [1:0] cfg_index;
    logic [47:0] cfg_data;

    row_scoreboard sb;
    bit  idle_on;       // random idling enabled
    bit  timed_out;
    longint cycles;

    rigid_body_frame_transform_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .quat_r(quat_r), .quat_i(quat_i), .quat_j(quat_j), .quat_k(quat_k),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .row(row), .last(last),
        .rot_c0(rot_c0), .rot_c1(rot_c1), .rot_c2(rot_c2),
        .translation(translation),
        .inertia_c0(inertia_c0), .inertia_c1(inertia_c1), .inertia_c2(inertia_c2),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // cycle counter doubling as the watchdog
    initial
    begin
        cycles = 0;
        timed_out = 1'b0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                timed_out = 1'b1;
            end
        end
    end

    // result side: random stall bursts, check each accepted row
    initial
    begin
        row_result_t got;
        int burst;
        out_stall = 1'b0;
        burst = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.row = row;
                got.last = last;
                got.trans = translation;
                got.rot[0] = rot_c0;
                got.rot[1] = rot_c1;
                got.rot[2] = rot_c2;
                got.inert[0] = inertia_c0;
                got.inert[1] = inertia_c1;
                got.inert[2] = inertia_c2;
                sb.check_row(got);
            end
            if (burst > 0)
                burst--;
            else if (idle_on && $urandom_range(0, 5) == 0)
                burst = $urandom_range(1, 4);
            out_stall <= (burst > 0);
        end
    end

    // one body update transaction, with optional idle burst before it
    task automatic send_body(body_item_t b);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        quat_r <= b.qr;
        quat_i <= b.qi;
        quat_j <= b.qj;
        quat_k <= b.qk;
        pos_x <= b.px;
        pos_y <= b.py;
        pos_z <= b.pz;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_body(b);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_rows.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // valid stays high between back-to-back writes; the caller drops it
    task automatic write_reg(logic [1:0] idx, logic [47:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_inertia(idx, val);
    endtask

    task automatic set_inertia(logic [47:0] r0, logic [47:0] r1, logic [47:0] r2);
        write_reg(CFG_ROW0, r0);
        write_reg(CFG_ROW1, r1);
        write_reg(CFG_ROW2, r2);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [47:0] rand_row();
        return {16'($urandom), 16'($urandom), 16'($urandom)};
    endfunction

    // near-unit quaternion if unit_like: one large component, small others of random sign; else all random
    function automatic body_item_t rand_body(bit unit_like);
        body_item_t b;
        b.px = $urandom;
        b.py = $urandom;
        b.pz = $urandom;
        if (unit_like)
        begin
            b.qr = $signed(16'($urandom_range(0, 8192))) - 16'sd4096;
            b.qi = $signed(16'($urandom_range(0, 8192))) - 16'sd4096;
            b.qj = $signed(16'($urandom_range(0, 8192))) - 16'sd4096;
            b.qk = $signed(16'($urandom_range(0, 8192))) - 16'sd4096;
            case ($urandom_range(0, 3))
                0: b.qr = 16'sd16384 - 16'($urandom_range(0, 3000));
                1: b.qi = 16'sd16384 - 16'($urandom_range(0, 3000));
                2: b.qj = -16'sd16384 + 16'($urandom_range(0, 3000));
                default: b.qk = 16'sd16384 - 16'($urandom_range(0, 3000));
            endcase
        end
        else
        begin
            b.qr = 16'($urandom);
            b.qi = 16'($urandom);
            b.qj = 16'($urandom);
            b.qk = 16'($urandom);
        end
        return b;
    endfunction

    function automatic body_item_t mk(int r, int i, int j, int k, int x, int y, int z);
        body_item_t b;
        b.qr = 16'(r);
        b.qi = 16'(i);
        b.qj = 16'(j);
        b.qk = 16'(k);
        b.px = x;
        b.py = y;
        b.pz = z;
        return b;
    endfunction

    initial
    begin
        sb = new();
        idle_on = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        quat_r = '0;
        quat_i = '0;
        quat_j = '0;
        quat_k = '0;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset inertia, identity and edge quaternions
        send_body(mk(16384, 0, 0, 0, 32'h7fffffff, 32'h80000000, 0));
        send_body(mk(0, 16384, 0, 0, -1, 1, 65536));
        drain();

        // identity-like diagonal tensor
        set_inertia(48'h0000_0000_1000, 48'h0000_1000_0000, 48'h1000_0000_0000);
        send_body(mk(16384, 0, 0, 0, 1, 2, 3));
        send_body(mk(0, 0, 16384, 0, 0, 0, 0));
        send_body(mk(0, 0, 0, 16384, -65536, 0, 0));
        send_body(mk(11585, 11585, 0, 0, 5, 6, 7));
        send_body(mk(-16384, 0, 0, 0, 0, 0, 0));
        drain();

        // extreme tensor values: all maximum, then all minimum
        set_inertia(48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff);
        send_body(mk(16384, 0, 0, 0, 0, 0, 0));
        send_body(mk(8192, 8192, 8192, 8192, 0, 0, 0));
        // non-unit quaternions saturate
        send_body(mk(32767, 32767, 32767, 32767, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        send_body(mk(-32768, -32768, -32768, -32768, 32'h80000000, 32'h80000000, 32'h80000000));
        send_body(mk(0, 32767, -32768, 0, 0, 0, 0));
        drain();
        set_inertia(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000);
        send_body(mk(-32768, 32767, 0, -32768, 1, 1, 1));
        send_body(mk(11585, 0, 11585, 0, 2, 2, 2));
        send_body(mk(0, 0, 0, 0, 3, 3, 3));
        drain();

        // random phases with a fresh tensor each
        idle_on = 1'b1;
        for (int p = 0; p < 4; p++)
        begin
            set_inertia(rand_row(), rand_row(), rand_row());
            for (int n = 0; n < 45; n++)
                send_body(rand_body($urandom_range(0, 3) != 0));
            drain();
        end

        // final stretch without idling on either side
        idle_on = 1'b0;
        set_inertia(rand_row(), rand_row(), rand_row());
        for (int n = 0; n < 30; n++)
            send_body(rand_body($urandom_range(0, 3) != 0));
        drain();

        if (timed_out)
            $display("testbench: errors");
        else if (sb.mismatches == 0 && sb.pending_rows.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // watchdog exit if the stimulus never completes
    initial
    begin
        wait (timed_out);
        $display("testbench: errors");
        $finish;
    end
endmodule
